### hw/rtl/wsd_pkg.sv
// Shared types and constants of the WebSocket binary frame deframer.
package wsd_pkg;

  localparam int unsigned NumClients = 4;
  localparam int unsigned ClientW    = 2;
  localparam int unsigned QueueDepth = 2;

  // WebSocket receive phases
  localparam logic [2:0] PhHdr0    = 3'd0;
  localparam logic [2:0] PhHdr1    = 3'd1;
  localparam logic [2:0] PhExt16   = 3'd2;
  localparam logic [2:0] PhExt64   = 3'd3;
  localparam logic [2:0] PhMask    = 3'd4;
  localparam logic [2:0] PhPayload = 3'd5;

  // Inner framer phases
  localparam logic [1:0] InIdle = 2'd0;
  localparam logic [1:0] InMark = 2'd1;
  localparam logic [1:0] InLen1 = 2'd2;
  localparam logic [1:0] InBody = 2'd3;

  localparam logic [7:0] Len16Escape  = 8'd126;
  localparam logic [7:0] Len64Escape  = 8'd127;
  localparam logic [3:0] OpcodeBinary = 4'h2;
  localparam logic [7:0] MarkerByte   = 8'h3C;
  localparam logic [15:0] MaxFrameReset = 16'd255;

  typedef enum logic {
    KIND_BYTE  = 1'b0,
    KIND_RESET = 1'b1
  } kind_e;

  // Classified word handed from front to back
  typedef struct packed {
    kind_e               kind;
    logic [ClientW-1:0]  client;
    logic [7:0]          data;
  } item_t;

endpackage

### hw/rtl/websocket_binary_frame_deframer.sv
// Top level of the WebSocket binary frame deframer.
//
// Input channel (s_axis): one word per received byte or connection event.
//   tuser = op (1 = connection opened, clear that connection's parser).
//   tdata = client number and raw byte.
// Output channel (m_axis): unmasked body bytes of inner binary frames
//   carried inside WebSocket opcode-2 frames, tagged with their connection;
//   tlast marks the final emitted byte of an inner frame.
// Configuration: max_frame_bytes_i written when max_frame_bytes_we_i is high;
//   bytes past this limit are consumed and dropped. Write it only when idle.
// Throughput: one word per cycle while the queue has room. Path: the queue
//   takes the word at its accepting edge and the per-connection update loads
//   the output register when the word leaves the queue, which waits while
//   the output register holds a byte that m_axis has not taken.
// The front end keeps accepting while the queue has room, so a stall on
//   m_axis backs up into the queue and then drops s_axis_tready_o.
// Reset: every connection returns to awaiting a header byte, the inner
//   framers go idle, the queue empties, and the limit returns to 255.
// Words for connections beyond the table are accepted and dropped.
module websocket_binary_frame_deframer
  import wsd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        max_frame_bytes_we_i,
  input  logic [15:0] max_frame_bytes_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // [1:0] client, [9:2] data, rest zero
  input  logic        s_axis_tuser_i,   // [0] op
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [1:0] source_client, [9:2] payload_byte
  output logic        m_axis_tlast_o
);

  logic [15:0]        max_frame_q;
  logic               q_valid, q_pop;
  item_t              q_item;
  logic [ClientW-1:0] out_client;
  logic [7:0]         out_byte;

  // Hold the frame limit register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_frame_q <= MaxFrameReset;
    end else if (max_frame_bytes_we_i) begin
      max_frame_q <= max_frame_bytes_i;
    end
  end

  wsd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_op_i     (s_axis_tuser_i),
    .in_client_i (s_axis_tdata_i[ClientW-1:0]),
    .in_data_i   (s_axis_tdata_i[ClientW+7:ClientW]),
    .q_valid_o   (q_valid),
    .q_item_o    (q_item),
    .q_pop_i     (q_pop)
  );

  wsd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .max_frame_i  (max_frame_q),
    .q_valid_i    (q_valid),
    .q_item_i     (q_item),
    .q_pop_o      (q_pop),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_client_o (out_client),
    .out_byte_o   (out_byte),
    .out_last_o   (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {6'd0, out_byte, out_client};

endmodule

### hw/rtl/wsd_front.sv
// Front end: accept input words, classify them and queue them for the back end.
module wsd_front
  import wsd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               in_op_i,
  input  logic [ClientW-1:0] in_client_i,
  input  logic [7:0]         in_data_i,
  output logic               q_valid_o,
  output item_t              q_item_o,
  input  logic               q_pop_i
);

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam logic [PtrW:0] DepthC = (PtrW+1)'(QueueDepth);
  localparam logic [ClientW:0] NumClientsC = (ClientW+1)'(NumClients);

  item_t           mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]   cnt_q, cnt_d;
  logic            keep, push, pop;
  item_t           item;

  assign in_ready_o = (cnt_q != DepthC);
  // Drop words for connections beyond the table.
  assign keep = ({1'b0, in_client_i} < NumClientsC);
  assign push = in_valid_i && in_ready_o && keep;
  assign pop  = q_pop_i && q_valid_o;

  assign item.kind   = in_op_i ? KIND_RESET : KIND_BYTE;
  assign item.client = in_client_i;
  assign item.data   = in_data_i;

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) cnt_d = cnt_q + 1'b1;
    else if (!push && pop) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= item;
  end

  assign q_valid_o = (cnt_q != '0);
  assign q_item_o  = mem_q[rd_ptr_q];

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= DepthC)
    else $error("queue count above depth");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == DepthC) |-> !push)
    else $error("push into full queue");

endmodule

### hw/rtl/wsd_back.sv
// Back end: per-connection WebSocket deframing, unmasking and inner framing.
module wsd_back
  import wsd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [15:0]        max_frame_i,
  input  logic               q_valid_i,
  input  item_t              q_item_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [ClientW-1:0] out_client_o,
  output logic [7:0]         out_byte_o,
  output logic               out_last_o
);

  logic [2:0]  ws_phase_q   [NumClients];
  logic [2:0]  ext_cnt_q    [NumClients];
  logic [3:0]  opcode_q     [NumClients];
  logic [63:0] pay_len_q    [NumClients];
  logic [63:0] pay_cnt_q    [NumClients];
  logic [31:0] mask_q       [NumClients];
  logic [1:0]  in_phase_q   [NumClients];
  logic [15:0] in_len_q     [NumClients];
  logic [15:0] in_cnt_q     [NumClients];

  logic [2:0]  ws_phase_d, ext_cnt_d, ext_inc;
  logic [3:0]  opcode_d;
  logic [63:0] pay_len_d, pay_cnt_d;
  logic [31:0] mask_d;
  logic [1:0]  in_phase_d;
  logic [15:0] in_len_d, in_cnt_d, lim;
  logic [16:0] n;
  logic [7:0]  b, key;
  logic        emit, pop;
  logic        out_valid_q, out_last_q;
  logic [ClientW-1:0] out_client_q;
  logic [7:0]  out_byte_q;
  logic [ClientW-1:0] c;

  assign c   = q_item_i.client;
  // Take the next word whenever the output register frees up.
  assign pop = q_valid_i && (!out_valid_q || out_ready_i);
  assign q_pop_o = pop;

  always_comb begin
    ws_phase_d = ws_phase_q[c];
    ext_cnt_d  = ext_cnt_q[c];
    opcode_d   = opcode_q[c];
    pay_len_d  = pay_len_q[c];
    pay_cnt_d  = pay_cnt_q[c];
    mask_d     = mask_q[c];
    in_phase_d = in_phase_q[c];
    in_len_d   = in_len_q[c];
    in_cnt_d   = in_cnt_q[c];
    ext_inc    = ext_cnt_q[c] + 3'd1;
    key        = mask_q[c][31 - 8*pay_cnt_q[c][1:0] -: 8];
    b          = q_item_i.data ^ key;
    n          = {1'b0, in_cnt_q[c]} + 17'd1;
    lim        = (max_frame_i < in_len_q[c]) ? max_frame_i : in_len_q[c];
    emit       = 1'b0;
    unique case (ws_phase_q[c])
      PhHdr1: begin
        pay_cnt_d = '0;
        ext_cnt_d = '0;
        if ({1'b0, q_item_i.data[6:0]} == Len16Escape) begin
          pay_len_d  = '0;
          ws_phase_d = PhExt16;
        end else if ({1'b0, q_item_i.data[6:0]} == Len64Escape) begin
          pay_len_d  = '0;
          ws_phase_d = PhExt64;
        end else begin
          pay_len_d  = {57'd0, q_item_i.data[6:0]};
          ws_phase_d = PhMask;
        end
      end
      PhExt16, PhExt64: begin
        pay_len_d = {pay_len_q[c][55:0], q_item_i.data};
        ext_cnt_d = ext_inc;
        if (ext_inc == ((ws_phase_q[c] == PhExt16) ? 3'd2 : 3'd0)) begin
          ext_cnt_d  = '0;
          ws_phase_d = PhMask;
        end
      end
      PhMask: begin
        mask_d    = {mask_q[c][23:0], q_item_i.data};
        ext_cnt_d = ext_inc;
        if (ext_inc >= 3'd4) begin
          ext_cnt_d  = '0;
          ws_phase_d = (pay_len_q[c] == '0) ? PhHdr0 : PhPayload;
        end
      end
      PhPayload: begin
        pay_cnt_d = pay_cnt_q[c] + 64'd1;
        if (pay_cnt_d >= pay_len_q[c]) ws_phase_d = PhHdr0;
        if (opcode_q[c] == OpcodeBinary) begin
          unique case (in_phase_q[c])
            InIdle: if (b == MarkerByte) in_phase_d = InMark;
            InMark: begin
              in_len_d   = {8'd0, b};
              in_phase_d = InLen1;
            end
            InLen1: begin
              in_len_d   = {b, in_len_q[c][7:0]};
              in_cnt_d   = '0;
              in_phase_d = (in_len_d != '0) ? InBody : InIdle;
            end
            default: begin
              emit     = (in_cnt_q[c] < max_frame_i);
              in_cnt_d = n[15:0];
              if (n >= {1'b0, in_len_q[c]}) in_phase_d = InIdle;
            end
          endcase
        end
      end
      default: begin
        opcode_d   = q_item_i.data[3:0];
        ws_phase_d = PhHdr1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumClients; i++) begin
        ws_phase_q[i] <= PhHdr0;
        ext_cnt_q[i]  <= '0;
        opcode_q[i]   <= '0;
        pay_len_q[i]  <= '0;
        pay_cnt_q[i]  <= '0;
        mask_q[i]     <= '0;
        in_phase_q[i] <= InIdle;
        in_len_q[i]   <= '0;
        in_cnt_q[i]   <= '0;
      end
      out_valid_q <= 1'b0;
    end else begin
      if (pop) begin
        if (q_item_i.kind == KIND_RESET) begin
          ws_phase_q[c] <= PhHdr0;
          ext_cnt_q[c]  <= '0;
          opcode_q[c]   <= '0;
          pay_len_q[c]  <= '0;
          pay_cnt_q[c]  <= '0;
          mask_q[c]     <= '0;
          in_phase_q[c] <= InIdle;
          in_len_q[c]   <= '0;
          in_cnt_q[c]   <= '0;
        end else begin
          ws_phase_q[c] <= ws_phase_d;
          ext_cnt_q[c]  <= ext_cnt_d;
          opcode_q[c]   <= opcode_d;
          pay_len_q[c]  <= pay_len_d;
          pay_cnt_q[c]  <= pay_cnt_d;
          mask_q[c]     <= mask_d;
          in_phase_q[c] <= in_phase_d;
          in_len_q[c]   <= in_len_d;
          in_cnt_q[c]   <= in_cnt_d;
        end
      end
      if (pop) out_valid_q <= emit && (q_item_i.kind == KIND_BYTE);
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      out_client_q <= c;
      out_byte_q   <= b;
      out_last_q   <= (n == {1'b0, lim});
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_client_o = out_client_q;
  assign out_byte_o   = out_byte_q;
  assign out_last_o   = out_last_q;

  a_pop_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> (!out_valid_q || out_ready_i))
    else $error("word taken while output blocked");

endmodule
